>>> sv/isp_pkg.sv
// Shared types and constants for the integer string parser.
package isp_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] CHAR_NUL      = 8'h00;
	localparam logic [7:0] CHAR_MINUS    = 8'h2d;
	localparam logic [7:0] CHAR_ZERO     = 8'h30;
	localparam logic [7:0] CHAR_NINE     = 8'h39;
	localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
	localparam logic [7:0] CHAR_UPPER_F  = 8'h46;
	localparam logic [7:0] CHAR_UPPER_X  = 8'h58;
	localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
	localparam logic [7:0] CHAR_LOWER_F  = 8'h66;
	localparam logic [7:0] CHAR_LOWER_X  = 8'h78;
	localparam logic [7:0] LETTER_OFFSET = 8'd10;

	localparam logic [1:0] WCODE_64 = 2'd0;
	localparam logic [1:0] WCODE_32 = 2'd1;
	localparam logic [1:0] WCODE_16 = 2'd2;
	localparam logic [1:0] WCODE_8  = 2'd3;

	localparam logic [63:0] HEX_NMAX  = 64'h0fff_ffff_ffff_ffff;
	localparam logic [3:0]  HEX_CMAX  = 4'd15;
	localparam logic [63:0] UDEC_NMAX = 64'd1844674407370955161;
	localparam logic [3:0]  UDEC_CMAX = 4'd5;
	localparam logic [63:0] SPOS_NMAX = 64'd922337203685477580;
	localparam logic [3:0]  SPOS_CMAX = 4'd7;
	localparam logic [63:0] SNEG_NMAX = 64'd922337203685477580;
	localparam logic [3:0]  SNEG_CMAX = 4'd8;

	localparam logic [1:0] POS_FIRST  = 2'd0;
	localparam logic [1:0] POS_SECOND = 2'd1;
	localparam logic [1:0] POS_LATER  = 2'd2;

	typedef struct packed {
		logic       is_nul;
		logic       is_minus;
		logic       is_x;
		logic       dec_ok;
		logic       hex_ok;
		logic [3:0] value;
	} char_class_t;

endpackage

>>> sv/integer_string_parser.sv
// Top level of the streaming decimal and hex integer string parser.
// The parser takes one character per transfer on the input channel and gives one result, ok and
// the 64-bit value, for each NUL that ends a string; other characters give no result. A leading
// 0x or 0X selects hex, otherwise the string is decimal with an optional minus sign for signed
// kinds, and the value is checked exactly against the limits of the kind in target_kind. It
// sustains one character per clock cycle while no stall holds it, set by the back end's
// per-character step of one bound compare and one multiply-by-ten (or shift-by-four) add on
// the 64-bit accumulator. A character reaches the back end through a four-entry queue, in which
// it is registered, and its result is loaded into the output register at the edge at which its
// NUL leaves the queue. A NUL waits at the head of the queue while an earlier result has not
// been taken, and the input stalls once the queue fills. Write target_kind only while no string
// is in flight.
module integer_string_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [2:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [63:0] number
);

	logic [2:0]           target_kind_q;
	logic                 queue_full;
	logic                 push;
	isp_pkg::char_class_t push_item;
	logic                 pop;
	logic                 head_valid;
	isp_pkg::char_class_t head_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_kind_q <= '0;
		end else if (cfg_wen) begin
			target_kind_q <= cfg_wdata;
		end
	end

	isp_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.char_code  (char_code),
		.queue_full (queue_full),
		.push       (push),
		.item       (push_item)
	);

	isp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	isp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.target_kind (target_kind_q),
		.head_valid  (head_valid),
		.head_item   (head_item),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.ok          (ok),
		.number      (number)
	);

endmodule

>>> sv/isp_front.sv
// Front end: accepts characters and classifies them into queue entries.
module isp_front (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [7:0]           char_code,
	input  logic                 queue_full,
	output logic                 push,
	output isp_pkg::char_class_t item
);

	logic is_dec;
	logic is_lower;
	logic is_upper;
	logic [7:0] letter_value;

	always_comb begin
		is_dec   = (char_code >= isp_pkg::CHAR_ZERO) && (char_code <= isp_pkg::CHAR_NINE);
		is_lower = (char_code >= isp_pkg::CHAR_LOWER_A) && (char_code <= isp_pkg::CHAR_LOWER_F);
		is_upper = (char_code >= isp_pkg::CHAR_UPPER_A) && (char_code <= isp_pkg::CHAR_UPPER_F);
		if (is_lower) begin
			letter_value = char_code - isp_pkg::CHAR_LOWER_A + isp_pkg::LETTER_OFFSET;
		end else begin
			letter_value = char_code - isp_pkg::CHAR_UPPER_A + isp_pkg::LETTER_OFFSET;
		end
		item.is_nul   = (char_code == isp_pkg::CHAR_NUL);
		item.is_minus = (char_code == isp_pkg::CHAR_MINUS);
		item.is_x     = (char_code == isp_pkg::CHAR_LOWER_X) ||
			(char_code == isp_pkg::CHAR_UPPER_X);
		item.dec_ok   = is_dec;
		item.hex_ok   = is_dec || is_lower || is_upper;
		item.value    = is_dec ? char_code[3:0] : letter_value[3:0];
	end

	assign in_ready = !queue_full;
	assign push     = in_valid && !queue_full;

endmodule

>>> sv/isp_queue.sv
// Short queue of classified characters between the front and back ends.
module isp_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  isp_pkg::char_class_t push_item,
	input  logic                 pop,
	output logic                 full,
	output logic                 head_valid,
	output isp_pkg::char_class_t head_item
);

	isp_pkg::char_class_t entries_q [isp_pkg::QUEUE_DEPTH];
	logic [isp_pkg::QUEUE_PTR_W-1:0] wr_ptr_q;
	logic [isp_pkg::QUEUE_PTR_W-1:0] rd_ptr_q;
	logic [isp_pkg::QUEUE_CNT_W-1:0] count_q;

	assign full       = (count_q == isp_pkg::QUEUE_CNT_W'(isp_pkg::QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> sv/isp_back.sv
// Back end: accumulates digits with overflow checks and issues results.
module isp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [2:0]           target_kind,
	input  logic                 head_valid,
	input  isp_pkg::char_class_t head_item,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 ok,
	output logic [63:0]          number
);

	logic [63:0] acc_q;
	logic [1:0]  pos_q;
	logic        neg_q;
	logic        hex_q;
	logic        seen_q;
	logic        failed_q;
	logic        out_valid_q;
	logic        ok_q;
	logic [63:0] number_q;

	logic        is_signed;
	logic        out_free;
	logic        take_prefix;
	logic        take_minus;
	logic        digit_ok;
	logic [63:0] nmax;
	logic [3:0]  cmax;
	logic        in_bound;
	logic [63:0] acc_next;
	logic        fin_ok;
	logic [63:0] fin_value;
	logic        fits;

	assign is_signed = target_kind[0];
	assign out_free  = !out_valid_q || out_ready;
	assign pop       = head_valid && (!head_item.is_nul || out_free);

	always_comb begin
		take_prefix = !hex_q && (pos_q == isp_pkg::POS_SECOND) && seen_q &&
			(acc_q == '0) && !neg_q && head_item.is_x;
		take_minus  = !hex_q && (pos_q == isp_pkg::POS_FIRST) && head_item.is_minus &&
			is_signed;
		digit_ok    = hex_q ? head_item.hex_ok : head_item.dec_ok;
		if (hex_q) begin
			nmax = isp_pkg::HEX_NMAX;
			cmax = isp_pkg::HEX_CMAX;
		end else if (!is_signed) begin
			nmax = isp_pkg::UDEC_NMAX;
			cmax = isp_pkg::UDEC_CMAX;
		end else if (neg_q) begin
			nmax = isp_pkg::SNEG_NMAX;
			cmax = isp_pkg::SNEG_CMAX;
		end else begin
			nmax = isp_pkg::SPOS_NMAX;
			cmax = isp_pkg::SPOS_CMAX;
		end
		in_bound = (acc_q < nmax) || ((acc_q == nmax) && (head_item.value <= cmax));
		if (hex_q) begin
			acc_next = {acc_q[59:0], head_item.value};
		end else begin
			acc_next = {acc_q[60:0], 3'b000} + {acc_q[62:0], 1'b0} +
				{60'd0, head_item.value};
		end
	end

	always_comb begin
		fin_ok = !failed_q && seen_q;
		if (fin_ok && !hex_q) begin
			if (neg_q && !is_signed) begin
				fin_ok = 1'b0;
			end else if (is_signed && !neg_q && acc_q[63]) begin
				fin_ok = 1'b0;
			end else if (neg_q && acc_q[63] && (acc_q[62:0] != '0)) begin
				fin_ok = 1'b0;
			end
		end
		fin_value = (!hex_q && neg_q) ? (64'd0 - acc_q) : acc_q;
		case (target_kind[2:1])
			isp_pkg::WCODE_64: fits = 1'b1;
			isp_pkg::WCODE_32: fits = is_signed ?
				((&fin_value[63:31]) || !(|fin_value[63:31])) : !(|fin_value[63:32]);
			isp_pkg::WCODE_16: fits = is_signed ?
				((&fin_value[63:15]) || !(|fin_value[63:15])) : !(|fin_value[63:16]);
			isp_pkg::WCODE_8:  fits = is_signed ?
				((&fin_value[63:7]) || !(|fin_value[63:7])) : !(|fin_value[63:8]);
			default:           fits = 1'b0;
		endcase
		fin_ok = fin_ok && fits;
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.is_nul) begin
			ok_q     <= fin_ok;
			number_q <= fin_ok ? fin_value : 64'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			pos_q       <= isp_pkg::POS_FIRST;
			neg_q       <= 1'b0;
			hex_q       <= 1'b0;
			seen_q      <= 1'b0;
			failed_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head_item.is_nul) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head_item.is_nul) begin
					acc_q       <= '0;
					pos_q       <= isp_pkg::POS_FIRST;
					neg_q       <= 1'b0;
					hex_q       <= 1'b0;
					seen_q      <= 1'b0;
					failed_q    <= 1'b0;
				end else begin
					if (!failed_q) begin
						if (take_prefix) begin
							hex_q  <= 1'b1;
							seen_q <= 1'b0;
						end else if (take_minus) begin
							neg_q <= 1'b1;
						end else if (digit_ok && in_bound) begin
							acc_q  <= acc_next;
							seen_q <= 1'b1;
						end else begin
							failed_q <= 1'b1;
						end
					end
					if (pos_q != isp_pkg::POS_LATER) begin
						pos_q <= pos_q + 1'b1;
					end
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign ok        = ok_q;
	assign number    = number_q;

endmodule

>>> verif/integer_string_parser_tb.sv
// Self-checking testbench for integer_string_parser: directed table, then random strings per kind.
`timescale 1ns / 100ps
module integer_string_parser_tb;

	localparam logic [2:0] KIND_U64 = 3'd0;
	localparam logic [2:0] KIND_S64 = 3'd1;
	localparam logic [2:0] KIND_U32 = 3'd2;
	localparam logic [2:0] KIND_S32 = 3'd3;
	localparam logic [2:0] KIND_U16 = 3'd4;
	localparam logic [2:0] KIND_S16 = 3'd5;
	localparam logic [2:0] KIND_U8  = 3'd6;
	localparam logic [2:0] KIND_S8  = 3'd7;

	localparam int IDLE_PCT          = 14;
	localparam int HOLD_CYCLES       = 150;
	localparam int SETTLE_CYCLES     = 8;
	localparam int STALL_LIMIT       = 1000;
	localparam int ITEM_TARGET       = 1200;
	localparam int STRINGS_PER_PHASE = 15;
	localparam int NROWS             = 28;
	localparam int NLIMITS           = 16;

	localparam logic [63:0] ALL_ONES    = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] S64_POS_MAG = 64'h7fff_ffff_ffff_ffff;
	localparam logic [63:0] S64_NEG_MAG = 64'h8000_0000_0000_0000;
	localparam logic [63:0] HEX_BOUND   = ALL_ONES / 64'd16;
	localparam logic [63:0] UDEC_BOUND  = ALL_ONES / 64'd10;
	localparam logic [63:0] SPOS_BOUND  = S64_POS_MAG / 64'd10;
	localparam logic [63:0] SNEG_BOUND  = S64_NEG_MAG / 64'd10;

	typedef struct packed {
		logic        ok;
		logic [63:0] number;
	} verdict_t;

	typedef struct {
		string       text;
		logic [2:0]  kind;
		bit          typed;
		logic        ok;
		logic [63:0] num;
	} dir_row_t;

	dir_row_t dir_rows [NROWS] = '{
		'{"", KIND_U64, 1'b1, 1'b0, 64'd0},
		'{"0", KIND_U64, 1'b1, 1'b1, 64'd0},
		'{"18446744073709551615", KIND_U64, 1'b1, 1'b1, ALL_ONES},
		'{"18446744073709551616", KIND_U64, 1'b1, 1'b0, 64'd0},
		'{"0x", KIND_U64, 1'b1, 1'b0, 64'd0},
		'{"0XFFFFFFFFFFFFFFFF", KIND_U64, 1'b1, 1'b1, ALL_ONES},
		'{"0x10000000000000000", KIND_U64, 1'b1, 1'b0, 64'd0},
		'{"-5", KIND_U64, 1'b1, 1'b0, 64'd0},
		'{"12a", KIND_U64, 1'b1, 1'b0, 64'd0},
		'{"\377", KIND_U64, 1'b1, 1'b0, 64'd0},
		'{"00x5", KIND_U64, 1'b0, 1'b0, 64'd0},
		'{"-", KIND_S64, 1'b1, 1'b0, 64'd0},
		'{"-0", KIND_S64, 1'b1, 1'b1, 64'd0},
		'{"-0x1", KIND_S64, 1'b1, 1'b0, 64'd0},
		'{"9223372036854775807", KIND_S64, 1'b1, 1'b1, S64_POS_MAG},
		'{"9223372036854775808", KIND_S64, 1'b1, 1'b0, 64'd0},
		'{"-9223372036854775808", KIND_S64, 1'b1, 1'b1, S64_NEG_MAG},
		'{"-9223372036854775809", KIND_S64, 1'b1, 1'b0, 64'd0},
		'{"4294967295", KIND_U32, 1'b1, 1'b1, 64'h0000_0000_ffff_ffff},
		'{"4294967296", KIND_U32, 1'b1, 1'b0, 64'd0},
		'{"0xaBcD", KIND_U32, 1'b0, 1'b0, 64'd0},
		'{"-2147483648", KIND_S32, 1'b1, 1'b1, 64'hffff_ffff_8000_0000},
		'{"65535", KIND_U16, 1'b0, 1'b0, 64'd0},
		'{"-32769", KIND_S16, 1'b1, 1'b0, 64'd0},
		'{"256", KIND_U8, 1'b1, 1'b0, 64'd0},
		'{"-128", KIND_S8, 1'b1, 1'b1, 64'hffff_ffff_ffff_ff80},
		'{"0xffffffffffffffff", KIND_S8, 1'b1, 1'b1, ALL_ONES},
		'{"127", KIND_S8, 1'b0, 1'b0, 64'd0}
	};

	string limit_texts [NLIMITS] = '{
		"18446744073709551615", "9223372036854775807", "9223372036854775808",
		"4294967295", "2147483647", "2147483648", "65535", "32767", "32768",
		"255", "127", "128", "0xffffffffffffffff", "0x7fffffffffffffff",
		"0xffffffff80000000", "0xffffffffffffff80"
	};

	logic        clk;
	logic        arst_n;
	logic        cfg_wen;
	logic [2:0]  cfg_wdata;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        out_valid;
	logic        out_ready;
	logic        ok;
	logic [63:0] number;

	logic [2:0]  kind_reg;
	logic [63:0] run_value;
	logic [1:0]  run_pos;
	bit          run_neg;
	bit          run_hex;
	bit          run_digit;
	bit          run_bad;

	verdict_t    verdicts_due [$];
	verdict_t    table_verdict;
	bit          table_pending = 1'b0;
	logic [7:0]  text_q [$];
	bit          calm = 1'b0;
	bit          hold_req = 1'b0;
	int          sent_items = 0;
	int          fault_cnt = 0;
	int          phase;

	integer_string_parser u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ok        (ok),
		.number    (number)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_run();
		run_value = '0;
		run_pos = isp_pkg::POS_FIRST;
		run_neg = 1'b0;
		run_hex = 1'b0;
		run_digit = 1'b0;
		run_bad = 1'b0;
	endfunction

	function automatic void digest_char(input logic [7:0] c, output bit done, output verdict_t v);
		int d;
		int w;
		int cmax;
		bit sgn;
		bit good;
		logic [63:0] val;
		logic [63:0] bound;
		logic [63:0] mult;
		sgn = kind_reg[0];
		done = 1'b0;
		v = '0;
		if (c == isp_pkg::CHAR_NUL) begin
			good = !run_bad && run_digit;
			val = '0;
			if (good && !run_hex) begin
				if (run_neg && !sgn) good = 1'b0;
				else if (sgn && !run_neg && run_value > S64_POS_MAG) good = 1'b0;
				else if (run_neg && run_value > S64_NEG_MAG) good = 1'b0;
			end
			if (good) begin
				val = (!run_hex && run_neg) ? (64'd0 - run_value) : run_value;
				w = 64 >> kind_reg[2:1];
				if (w < 64) begin
					if (sgn) good = (val + (64'd1 << (w - 1))) < (64'd1 << w);
					else good = val < (64'd1 << w);
				end
			end
			done = 1'b1;
			v.ok = good;
			v.number = good ? val : '0;
			clear_run();
		end else begin
			if (!run_bad) begin
				if (!run_hex && run_pos == isp_pkg::POS_SECOND && run_digit &&
						run_value == 0 && !run_neg &&
						(c == isp_pkg::CHAR_LOWER_X || c == isp_pkg::CHAR_UPPER_X)) begin
					run_hex = 1'b1;
					run_digit = 1'b0;
				end else if (!run_hex && run_pos == isp_pkg::POS_FIRST &&
						c == isp_pkg::CHAR_MINUS && sgn) begin
					run_neg = 1'b1;
				end else begin
					if (c >= isp_pkg::CHAR_ZERO && c <= isp_pkg::CHAR_NINE)
						d = c - isp_pkg::CHAR_ZERO;
					else if (run_hex && c >= isp_pkg::CHAR_LOWER_A && c <= isp_pkg::CHAR_LOWER_F)
						d = c - isp_pkg::CHAR_LOWER_A + 10;
					else if (run_hex && c >= isp_pkg::CHAR_UPPER_A && c <= isp_pkg::CHAR_UPPER_F)
						d = c - isp_pkg::CHAR_UPPER_A + 10;
					else d = -1;
					if (run_hex) begin
						bound = HEX_BOUND;
						cmax = 15;
						mult = 64'd16;
					end else if (!sgn) begin
						bound = UDEC_BOUND;
						cmax = 5;
						mult = 64'd10;
					end else if (run_neg) begin
						bound = SNEG_BOUND;
						cmax = 8;
						mult = 64'd10;
					end else begin
						bound = SPOS_BOUND;
						cmax = 7;
						mult = 64'd10;
					end
					if (d < 0) begin
						run_bad = 1'b1;
					end else if (run_value < bound || (run_value == bound && d <= cmax)) begin
						run_value = run_value * mult + 64'(d);
						run_digit = 1'b1;
					end else begin
						run_bad = 1'b1;
					end
				end
			end
			if (run_pos != isp_pkg::POS_LATER) run_pos = run_pos + 2'd1;
		end
	endfunction

	function automatic void make_text();
		int form;
		int n;
		int d;
		string lim;
		text_q.delete();
		form = $urandom_range(99);
		if (form < 60 && $urandom_range(99) < (kind_reg[0] ? 45 : 5))
			text_q.push_back(isp_pkg::CHAR_MINUS);
		if (form < 35) begin
			n = ($urandom_range(3) == 0) ? $urandom_range(15, 21) : $urandom_range(1, 6);
			repeat (n) text_q.push_back(isp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
		end else if (form < 60) begin
			lim = limit_texts[$urandom_range(NLIMITS - 1)];
			for (int i = 0; i < lim.len() - 1; i++) text_q.push_back(lim[i]);
			text_q.push_back(isp_pkg::CHAR_ZERO + 8'($urandom_range(9)));
		end else if (form < 85) begin
			text_q.push_back(isp_pkg::CHAR_ZERO);
			text_q.push_back($urandom_range(1) ? isp_pkg::CHAR_UPPER_X : isp_pkg::CHAR_LOWER_X);
			n = ($urandom_range(3) == 0) ? $urandom_range(15, 17) : $urandom_range(0, 6);
			repeat (n) begin
				d = $urandom_range(15);
				if (d < 10) text_q.push_back(isp_pkg::CHAR_ZERO + 8'(d));
				else text_q.push_back(($urandom_range(1) ? isp_pkg::CHAR_UPPER_A :
					isp_pkg::CHAR_LOWER_A) + 8'(d - 10));
			end
		end else begin
			n = $urandom_range(0, 5);
			repeat (n) text_q.push_back(8'($urandom_range(1, 255)));
		end
		if (form < 85 && text_q.size() != 0 && $urandom_range(99) < 15)
			text_q[$urandom_range(text_q.size() - 1)] = 8'($urandom_range(1, 255));
	endfunction

	task automatic send_item(input logic [7:0] c);
		bit done;
		verdict_t v;
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid <= 1'b1;
		char_code <= c;
		do @(posedge clk); while (!in_ready);
		digest_char(c, done, v);
		if (done) begin
			verdicts_due.push_back(table_pending ? table_verdict : v);
			table_pending = 1'b0;
		end
		sent_items++;
		@(negedge clk);
	endtask

	task automatic change_kind(input logic [2:0] k);
		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= k;
		@(negedge clk);
		cfg_wen <= 1'b0;
		kind_reg = k;
	endtask

	task automatic note_fault(input string what, input logic [63:0] want, input logic [63:0] got);
		fault_cnt++;
		if (fault_cnt <= 10)
			$display("mismatch %0d at %0t: %s expected %h got %h", fault_cnt, $time, what, want, got);
	endtask

	always @(posedge clk) begin
		verdict_t due;
		if (arst_n && out_valid && out_ready) begin
			if (verdicts_due.size() == 0) begin
				note_fault("unexpected result, number", 64'd0, number);
			end else begin
				due = verdicts_due.pop_front();
				if (ok !== due.ok) note_fault("ok", 64'(due.ok), 64'(ok));
				if (number !== due.number) note_fault("number", due.number, number);
			end
		end
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin : watchdog
		int stall;
		stall = 0;
		while (stall < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall = 0;
			else stall++;
		end
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		char_code = '0;
		kind_reg = KIND_U64;
		clear_run();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < NROWS; r++) begin
			if (r == 0 || dir_rows[r].kind != kind_reg) change_kind(dir_rows[r].kind);
			for (int i = 0; i < dir_rows[r].text.len(); i++) send_item(dir_rows[r].text[i]);
			table_pending = dir_rows[r].typed;
			table_verdict = '{ok: dir_rows[r].ok, number: dir_rows[r].num};
			send_item(isp_pkg::CHAR_NUL);
		end

		// Each phase opens with a drain and a new kind; one phase runs without gaps and
		// another starts with a long output stall while characters keep coming.
		phase = 0;
		while (sent_items < ITEM_TARGET) begin
			change_kind(phase < 8 ? 3'(phase) : 3'($urandom_range(7)));
			calm = (phase == 2);
			if (phase == 5) hold_req = 1'b1;
			repeat (STRINGS_PER_PHASE) begin
				make_text();
				foreach (text_q[i]) send_item(text_q[i]);
				send_item(isp_pkg::CHAR_NUL);
			end
			phase++;
		end
		calm = 1'b0;

		in_valid <= 1'b0;
		while (verdicts_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES * 2) @(negedge clk);
		if (fault_cnt == 0) $display("[ OK ] regression clean");
		else $display("[FAIL] regression broken");
		$finish;
	end

endmodule
